### rtl/core/ilst_pkg.sv
// ----------------------------------------------------------------------------
// ilst_pkg
// Shared constants, register indexes and helper functions of the
// illuminated line shading texel core.
// ----------------------------------------------------------------------------
package ilst_pkg;

   // raster defaults and coordinate table depth (set by the 8-bit texel fields)
   localparam int TexWidthDefault  = 256;
   localparam int TexHeightDefault = 256;
   localparam int CoordTabDepth    = 256;

   // configuration port
   localparam int CsrIndexWidth = 3;
   localparam int CsrDataWidth  = 16;

   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_USE_AMBIENT  = 3'd0,
      CSR_USE_DIFFUSE  = 3'd1,
      CSR_USE_SPECULAR = 3'd2,
      CSR_SPEC_EXP     = 3'd3,
      CSR_BASE_RED     = 3'd4,
      CSR_BASE_GREEN   = 3'd5,
      CSR_BASE_BLUE    = 3'd6
   } csr_index_type;

   // Q.16 shading constants
   localparam logic [16:0] ONE_Q16     = 17'd65536;
   localparam logic [15:0] AMBIENT_Q16 = 16'd32768;
   localparam logic [14:0] DIFFUSE_K   = 15'd26214;
   localparam logic [15:0] SPECULAR_K  = 16'd52429;

   // 2^(-2^-(k+1)) in Q0.16
   function automatic logic [15:0] exp2_neg(input logic [3:0] k);
      logic [15:0] c;
      case (k)
         4'd0:    c = 16'd46341;
         4'd1:    c = 16'd55109;
         4'd2:    c = 16'd60097;
         4'd3:    c = 16'd62757;
         4'd4:    c = 16'd64132;
         4'd5:    c = 16'd64830;
         4'd6:    c = 16'd65182;
         4'd7:    c = 16'd65359;
         4'd8:    c = 16'd65447;
         4'd9:    c = 16'd65492;
         4'd10:   c = 16'd65514;
         4'd11:   c = 16'd65525;
         4'd12:   c = 16'd65530;
         4'd13:   c = 16'd65533;
         default: c = 16'd65535;
      endcase
      return c;
   endfunction

   // floor(sqrt(d)) for d < 2^31, bitwise root; used to build constant tables
   function automatic logic [15:0] root16(input logic [31:0] d);
      logic [31:0] rem;
      logic [31:0] res;
      logic [31:0] bit_w;
      rem   = d;
      res   = 32'd0;
      bit_w = 32'h4000_0000;
      for (int k = 0; k < 16; k++) begin
         if (rem >= res + bit_w) begin
            rem = rem - (res + bit_w);
            res = (res >> 1) + bit_w;
         end else begin
            res = res >> 1;
         end
         bit_w = bit_w >> 2;
      end
      return res[15:0];
   endfunction

endpackage

### rtl/core/ilst_if.sv
// ----------------------------------------------------------------------------
// ilst_req_if / ilst_rsp_if
// Valid/ready channels carrying texel coordinates in and RGB words out.
// ----------------------------------------------------------------------------
interface ilst_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] texel_x;
   logic [7:0] texel_y;
   modport source (output valid, output texel_x, output texel_y, input ready);
   modport sink   (input valid, input texel_x, input texel_y, output ready);
endinterface

interface ilst_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] red;
   logic [7:0] green;
   logic [7:0] blue;
   modport source (output valid, output red, output green, output blue, input ready);
   modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

### rtl/core/ilst_front.sv
// ----------------------------------------------------------------------------
// ilst_front
// Coordinate to dot product / normal lookup and reflection term, 3 stages.
// ----------------------------------------------------------------------------
module ilst_front
   import ilst_pkg::*;
#(
   parameter int TEX_WIDTH  = TexWidthDefault,
   parameter int TEX_HEIGHT = TexHeightDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        pipe_en,
   input  logic        in_valid,
   input  logic [7:0]  texel_x,
   input  logic [7:0]  texel_y,
   output logic        out_valid,
   output logic [14:0] refl,
   output logic [15:0] ln2
);

   logic signed [15:0] vt_tab [CoordTabDepth];
   logic        [15:0] vn_tab [CoordTabDepth];
   logic signed [15:0] lt_tab [CoordTabDepth];
   logic        [15:0] ln_tab [CoordTabDepth];
   logic        [15:0] l2_tab [CoordTabDepth];

   // constant tables, built at elaboration from the raster size
   for (genvar i = 0; i < CoordTabDepth; i++) begin : g_tab
      localparam int     XS   = TEX_WIDTH - 1;
      localparam int     XI   = (i > XS) ? XS : i;
      localparam bit     XNEG = (2 * XI) < XS;
      localparam longint XMAG = XNEG ? XS - 2 * XI : 2 * XI - XS;
      localparam longint XQ0  = (XMAG * 32768 + XS / 2) / XS;
      localparam int     XQ   = (XQ0 > 32767) ? 32767 : int'(XQ0);
      localparam int     YS   = TEX_HEIGHT - 1;
      localparam int     YI   = (i > YS) ? YS : i;
      localparam bit     YNEG = (2 * YI) < YS;
      localparam longint YMAG = YNEG ? YS - 2 * YI : 2 * YI - YS;
      localparam longint YQ0  = (YMAG * 32768 + YS / 2) / YS;
      localparam int     YQ   = (YQ0 > 32767) ? 32767 : int'(YQ0);
      localparam logic [15:0] YN = root16(32'((1 << 30) - YQ * YQ));
      localparam int     YL2  = (int'(YN) * int'(YN)) >> 15;

      assign vt_tab[i] = XNEG ? -16'(XQ) : 16'(XQ);
      assign vn_tab[i] = root16(32'((1 << 30) - XQ * XQ));
      assign lt_tab[i] = YNEG ? -16'(YQ) : 16'(YQ);
      assign ln_tab[i] = YN;
      assign l2_tab[i] = 16'(YL2);
   end

   logic               v1_ff, v2_ff, v3_ff;
   logic signed [15:0] vt_ff, lt_ff;
   logic        [15:0] vn_ff, ln_ff;
   logic        [15:0] l2a_ff, l2b_ff, l2c_ff;
   logic        [31:0] pn_ff;
   logic signed [31:0] pt_ff;
   logic        [14:0] refl_ff;
   logic        [14:0] refl_in;
   logic signed [32:0] diff;
   logic        [17:0] diff_sh;

   // reflection: clamp negative, drop 15 bits, saturate
   always_comb begin
      diff    = $signed({1'b0, pn_ff}) - 33'(pt_ff);
      diff_sh = diff[32:15];
      if (diff < 0) begin
         refl_in = 15'd0;
      end else if (diff_sh > 18'd32767) begin
         refl_in = 15'h7fff;
      end else begin
         refl_in = diff_sh[14:0];
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (pipe_en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   // data stages: lookup, products, reflection
   always_ff @(posedge clock) begin
      if (pipe_en) begin
         vt_ff   <= vt_tab[texel_x];
         vn_ff   <= vn_tab[texel_x];
         lt_ff   <= lt_tab[texel_y];
         ln_ff   <= ln_tab[texel_y];
         l2a_ff  <= l2_tab[texel_y];
         pn_ff   <= ln_ff * vn_ff;
         pt_ff   <= lt_ff * vt_ff;
         l2b_ff  <= l2a_ff;
         refl_ff <= refl_in;
         l2c_ff  <= l2b_ff;
      end
   end

   assign out_valid = v3_ff;
   assign refl      = refl_ff;
   assign ln2       = l2c_ff;

endmodule

### rtl/core/ilst_log2.sv
// ----------------------------------------------------------------------------
// ilst_log2
// Negative log2 of the reflection term by normalization and 16 squaring
// stages; 18 stages in all.
// ----------------------------------------------------------------------------
module ilst_log2 (
   input  logic        clock,
   input  logic        reset,
   input  logic        pipe_en,
   input  logic        in_valid,
   input  logic [14:0] refl,
   input  logic [15:0] ln2_i,
   output logic        out_valid,
   output logic [19:0] neg_log,
   output logic        refl_zero,
   output logic [15:0] ln2_o
);

   localparam int Steps = 16;

   logic        v_ff    [Steps+2];
   logic [30:0] m_ff    [Steps+1];
   logic [15:0] fr_ff   [Steps+1];
   logic [3:0]  p_ff    [Steps+1];
   logic        z_ff    [Steps+2];
   logic [15:0] l2_ff   [Steps+2];
   logic [19:0] nl_ff;
   logic [3:0]  msb;
   logic [30:0] m_in;

   // leading one position
   always_comb begin
      msb = 4'd0;
      for (int b = 1; b < 15; b++) begin
         if (refl[b]) msb = 4'(b);
      end
      m_in = 31'(refl) << (5'd30 - 5'(msb));
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < Steps + 2; s++) v_ff[s] <= 1'b0;
      end else if (pipe_en) begin
         v_ff[0] <= in_valid;
         for (int s = 1; s < Steps + 2; s++) v_ff[s] <= v_ff[s-1];
      end
   end

   // normalization stage
   always_ff @(posedge clock) begin
      if (pipe_en) begin
         m_ff[0]  <= m_in;
         fr_ff[0] <= 16'd0;
         p_ff[0]  <= msb;
         z_ff[0]  <= (refl == 15'd0);
         l2_ff[0] <= ln2_i;
      end
   end

   // one squaring step per stage, one fraction bit each
   for (genvar k = 1; k <= Steps; k++) begin : g_sq
      logic [61:0] sq;
      logic [31:0] t;
      assign sq = m_ff[k-1] * m_ff[k-1];
      assign t  = sq[61:30];
      always_ff @(posedge clock) begin
         if (pipe_en) begin
            if (t[31]) begin
               m_ff[k]  <= t[31:1];
               fr_ff[k] <= fr_ff[k-1] | (16'd1 << (Steps - k));
            end else begin
               m_ff[k]  <= t[30:0];
               fr_ff[k] <= fr_ff[k-1];
            end
            p_ff[k]  <= p_ff[k-1];
            z_ff[k]  <= z_ff[k-1];
            l2_ff[k] <= l2_ff[k-1];
         end
      end
   end

   // negate: 15 - log2
   always_ff @(posedge clock) begin
      if (pipe_en) begin
         nl_ff           <= {4'd15, 16'd0} - {p_ff[Steps], fr_ff[Steps]};
         z_ff[Steps+1]   <= z_ff[Steps];
         l2_ff[Steps+1]  <= l2_ff[Steps];
      end
   end

   assign out_valid = v_ff[Steps+1];
   assign neg_log   = nl_ff;
   assign refl_zero = z_ff[Steps+1];
   assign ln2_o     = l2_ff[Steps+1];

endmodule

### rtl/core/ilst_exp2.sv
// ----------------------------------------------------------------------------
// ilst_exp2
// Exponent scaling and exp2 of the negative log by 16 factor stages;
// gives the Q1.16 specular power. 18 stages in all.
// ----------------------------------------------------------------------------
module ilst_exp2
   import ilst_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        pipe_en,
   input  logic        in_valid,
   input  logic [19:0] neg_log,
   input  logic        refl_zero,
   input  logic [15:0] ln2_i,
   input  logic [15:0] spec_exp,
   output logic        out_valid,
   output logic [16:0] power,
   output logic [15:0] ln2_o
);

   localparam int Steps = 16;

   logic        v_ff   [Steps+2];
   logic [16:0] v_val  [Steps+1];
   logic [15:0] fp_ff  [Steps+1];
   logic [3:0]  sh_ff  [Steps+1];
   logic        big_ff [Steps+1];
   logic        z_ff   [Steps+1];
   logic [15:0] l2_ff  [Steps+2];
   logic [16:0] pw_ff;
   logic [35:0] y;

   assign y = spec_exp * neg_log;

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < Steps + 2; s++) v_ff[s] <= 1'b0;
      end else if (pipe_en) begin
         v_ff[0] <= in_valid;
         for (int s = 1; s < Steps + 2; s++) v_ff[s] <= v_ff[s-1];
      end
   end

   // scale by the Q8.8 exponent, split integer and fraction
   always_ff @(posedge clock) begin
      if (pipe_en) begin
         v_val[0]  <= ONE_Q16;
         fp_ff[0]  <= y[23:8];
         sh_ff[0]  <= y[27:24];
         big_ff[0] <= |y[35:28];
         z_ff[0]   <= refl_zero;
         l2_ff[0]  <= ln2_i;
      end
   end

   // one rounded factor per stage
   for (genvar k = 0; k < Steps; k++) begin : g_fac
      logic [32:0] prod;
      logic [32:0] rnd;
      assign prod = v_val[k] * exp2_neg(4'(k));
      assign rnd  = prod + 33'd32768;
      always_ff @(posedge clock) begin
         if (pipe_en) begin
            v_val[k+1]  <= fp_ff[k][Steps-1-k] ? rnd[32:16] : v_val[k];
            fp_ff[k+1]  <= fp_ff[k];
            sh_ff[k+1]  <= sh_ff[k];
            big_ff[k+1] <= big_ff[k];
            z_ff[k+1]   <= z_ff[k];
            l2_ff[k+1]  <= l2_ff[k];
         end
      end
   end

   // integer shift and special cases
   always_ff @(posedge clock) begin
      if (pipe_en) begin
         if (spec_exp == 16'd0) begin
            pw_ff <= ONE_Q16;
         end else if (z_ff[Steps] || big_ff[Steps]) begin
            pw_ff <= 17'd0;
         end else begin
            pw_ff <= v_val[Steps] >> sh_ff[Steps];
         end
         l2_ff[Steps+1] <= l2_ff[Steps];
      end
   end

   assign out_valid = v_ff[Steps+1];
   assign power     = pw_ff;
   assign ln2_o     = l2_ff[Steps+1];

endmodule

### rtl/core/ilst_shade.sv
// ----------------------------------------------------------------------------
// ilst_shade
// Ambient, diffuse and specular sum per channel and byte conversion;
// 3 stages, the last being the result word register.
// ----------------------------------------------------------------------------
module ilst_shade
   import ilst_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        pipe_en,
   input  logic        in_valid,
   input  logic [16:0] power,
   input  logic [15:0] ln2,
   input  logic        use_ambient,
   input  logic        use_diffuse,
   input  logic        use_specular,
   input  logic [7:0]  base_red,
   input  logic [7:0]  base_green,
   input  logic [7:0]  base_blue,
   output logic        out_valid,
   output logic [7:0]  red,
   output logic [7:0]  green,
   output logic [7:0]  blue
);

   logic        va_ff, vb_ff, vc_ff;
   logic [16:0] cma_ff, cmb_ff;
   logic [22:0] kb_ff [3];
   logic [15:0] l2_ff;
   logic [15:0] d_ff  [3];
   logic [7:0]  by_ff [3];
   logic [32:0] spec_prod;
   logic [7:0]  base [3];

   assign spec_prod = SPECULAR_K * power;
   assign base[0]   = base_red;
   assign base[1]   = base_green;
   assign base[2]   = base_blue;

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
         vc_ff <= 1'b0;
      end else if (pipe_en) begin
         va_ff <= in_valid;
         vb_ff <= va_ff;
         vc_ff <= vb_ff;
      end
   end

   // common term and scaled base colors
   always_ff @(posedge clock) begin
      if (pipe_en) begin
         cma_ff <= (use_ambient ? 17'(AMBIENT_Q16) : 17'd0)
                 + (use_specular ? 17'(spec_prod[32:16]) : 17'd0);
         for (int c = 0; c < 3; c++) kb_ff[c] <= DIFFUSE_K * base[c];
         l2_ff  <= ln2;
      end
   end

   // diffuse term and byte per channel
   for (genvar c = 0; c < 3; c++) begin : g_ch
      logic [38:0] dprod;
      logic [17:0] s;
      logic [25:0] s255;
      assign dprod = kb_ff[c] * l2_ff;
      assign s     = 18'(cmb_ff) + 18'(d_ff[c]);
      assign s255  = (26'(s) << 8) - 26'(s);
      always_ff @(posedge clock) begin
         if (pipe_en) begin
            d_ff[c]  <= use_diffuse ? dprod[38:23] : 16'd0;
            by_ff[c] <= (s >= 18'(ONE_Q16)) ? 8'hff : s255[23:16];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) cmb_ff <= cma_ff;
   end

   assign out_valid = vc_ff;
   assign red       = by_ff[0];
   assign green     = by_ff[1];
   assign blue      = by_ff[2];

endmodule

### rtl/core/illuminated_line_shading_texel_core.sv
// ----------------------------------------------------------------------------
// illuminated_line_shading_texel_core
// Illuminated line (anisotropic) shading texture generator: one texel
// coordinate word in, one RGB word out.
//
// The req channel takes texel_x/texel_y words; the rsp channel returns
// red/green/blue bytes in the same order. Both are valid/ready.
// The csr port writes the enables, the Q8.8 specular exponent and the
// base color; write only while no word is in flight.
// From accepted req word to rsp valid a word passes 3 lookup and
// reflection stages, 18 log2 stages (16 squarings), 18 exp2 stages
// (16 factor multiplies) and 3 shading stages. Throughput is one texel
// per cycle unless rsp stalls; the whole pipeline advances together.
// When rsp is stalled the pipeline holds and req.ready drops, so no
// word is lost or repeated. Reset is synchronous: it empties the
// pipeline and loads the register defaults; there is no clearing pass.
// ----------------------------------------------------------------------------
module illuminated_line_shading_texel_core
   import ilst_pkg::*;
#(
   parameter int TEX_WIDTH  = TexWidthDefault,
   parameter int TEX_HEIGHT = TexHeightDefault
) (
   input  logic                     clock,
   input  logic                     reset,
   ilst_req_if.sink                 req,
   ilst_rsp_if.source               rsp,
   input  logic                     csr_we,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [CsrDataWidth-1:0]  csr_wdata
);

   logic        use_amb_ff, use_dif_ff, use_spc_ff;
   logic [15:0] spec_exp_ff;
   logic [7:0]  base_r_ff, base_g_ff, base_b_ff;
   logic        pipe_en;

   logic        f_valid;
   logic [14:0] f_refl;
   logic [15:0] f_ln2;
   logic        l_valid;
   logic [19:0] l_neg_log;
   logic        l_zero;
   logic [15:0] l_ln2;
   logic        e_valid;
   logic [16:0] e_power;
   logic [15:0] e_ln2;

   // whole pipeline advances unless the result word is held
   assign pipe_en   = !rsp.valid || rsp.ready;
   assign req.ready = pipe_en;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         use_amb_ff  <= 1'b1;
         use_dif_ff  <= 1'b1;
         use_spc_ff  <= 1'b1;
         spec_exp_ff <= 16'd15360;
         base_r_ff   <= 8'd102;
         base_g_ff   <= 8'd102;
         base_b_ff   <= 8'd179;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_USE_AMBIENT:  use_amb_ff  <= csr_wdata[0];
            CSR_USE_DIFFUSE:  use_dif_ff  <= csr_wdata[0];
            CSR_USE_SPECULAR: use_spc_ff  <= csr_wdata[0];
            CSR_SPEC_EXP:     spec_exp_ff <= csr_wdata;
            CSR_BASE_RED:     base_r_ff   <= csr_wdata[7:0];
            CSR_BASE_GREEN:   base_g_ff   <= csr_wdata[7:0];
            CSR_BASE_BLUE:    base_b_ff   <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   ilst_front #(
      .TEX_WIDTH  (TEX_WIDTH),
      .TEX_HEIGHT (TEX_HEIGHT)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .pipe_en   (pipe_en),
      .in_valid  (req.valid),
      .texel_x   (req.texel_x),
      .texel_y   (req.texel_y),
      .out_valid (f_valid),
      .refl      (f_refl),
      .ln2       (f_ln2)
   );

   ilst_log2 u_log2 (
      .clock     (clock),
      .reset     (reset),
      .pipe_en   (pipe_en),
      .in_valid  (f_valid),
      .refl      (f_refl),
      .ln2_i     (f_ln2),
      .out_valid (l_valid),
      .neg_log   (l_neg_log),
      .refl_zero (l_zero),
      .ln2_o     (l_ln2)
   );

   ilst_exp2 u_exp2 (
      .clock     (clock),
      .reset     (reset),
      .pipe_en   (pipe_en),
      .in_valid  (l_valid),
      .neg_log   (l_neg_log),
      .refl_zero (l_zero),
      .ln2_i     (l_ln2),
      .spec_exp  (spec_exp_ff),
      .out_valid (e_valid),
      .power     (e_power),
      .ln2_o     (e_ln2)
   );

   ilst_shade u_shade (
      .clock        (clock),
      .reset        (reset),
      .pipe_en      (pipe_en),
      .in_valid     (e_valid),
      .power        (e_power),
      .ln2          (e_ln2),
      .use_ambient  (use_amb_ff),
      .use_diffuse  (use_dif_ff),
      .use_specular (use_spc_ff),
      .base_red     (base_r_ff),
      .base_green   (base_g_ff),
      .base_blue    (base_b_ff),
      .out_valid    (rsp.valid),
      .red          (rsp.red),
      .green        (rsp.green),
      .blue         (rsp.blue)
   );

endmodule
